>>> hw/rtl/assert_macros.svh
// Assertion helpers for the stripe hash checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define SKH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define SKH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/skh_pkg.sv
package skh_pkg;

   localparam logic [31:0] PR1 = 32'h9E37_79B1;
   localparam logic [31:0] PR2 = 32'h85EB_CA77;
   localparam logic [31:0] PR3 = 32'hC2B2_AE3D;
   localparam logic [31:0] PR4 = 32'h27D4_EB2F;

   localparam int NUM_LANES = 4;

   localparam logic [NUM_LANES-1:0][31:0] LANE_INIT = '{
      32'(0) - PR1,
      32'h0000_0000,
      PR2,
      PR1 + PR2
   };

   localparam logic [4:0] FULL_STRIPE = 5'd16;
   localparam logic [4:0] HALF_STRIPE = 5'd8;

   typedef struct packed {
      logic load;
      logic mix;
      logic clear;
   } lane_ctrl_type;

   typedef struct packed {
      logic fold;
      logic tmul;
      logic trot;
      logic av1;
      logic av2;
   } merge_ctrl_type;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MIX  = 8'b0000_0010,
      ST_FOLD = 8'b0000_0100,
      ST_TMUL = 8'b0000_1000,
      ST_TROT = 8'b0001_0000,
      ST_AV1  = 8'b0010_0000,
      ST_AV2  = 8'b0100_0000,
      ST_OUT  = 8'b1000_0000
   } state_type;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int r);
      rotl32 = (v << r) | (v >> (32 - r));
   endfunction

   // keep bytes below n, n in 0..8
   function automatic logic [63:0] low_bytes(input logic [3:0] n);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < n) begin
            m[8*i +: 8] = 8'hFF;
         end
      end
      low_bytes = m;
   endfunction

endpackage

>>> hw/rtl/skh_lane.sv
module skh_lane
   import skh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lane_ctrl_type ctrl,
   input  logic [31:0]   word,
   input  logic [31:0]   init_value,
   output logic [31:0]   acc
);

   logic [31:0] prod_ff, prod_in;
   logic [31:0] acc_ff, acc_in;

   always_comb begin
      prod_in = prod_ff;
      if (ctrl.load) begin
         prod_in = 32'(word * PR2);
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = init_value;
      end else if (ctrl.mix) begin
         acc_in = 32'(rotl32(32'(acc_ff + prod_ff), 13) * PR1);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= init_value;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

>>> hw/rtl/skh_merge.sv
module skh_merge
   import skh_pkg::*;
(
   input  logic                          clock,
   input  merge_ctrl_type                ctrl,
   input  logic [NUM_LANES-1:0][31:0]    lanes,
   input  logic [31:0]                   tail_word,
   output logic [31:0]                   hash
);

   logic [31:0] h_ff, h_in;
   logic [31:0] p_ff, p_in;
   logic [31:0] mul_a, mul_b, product;
   logic [31:0] fold_sum;

   assign fold_sum = 32'(rotl32(lanes[0], 1) + rotl32(lanes[1], 7)
                       + rotl32(lanes[2], 12) + rotl32(lanes[3], 18));

   // one shared multiplier for tail rounds and avalanche
   always_comb begin
      mul_a = tail_word;
      mul_b = PR3;
      if (ctrl.trot) begin
         mul_a = rotl32(32'(h_ff + p_ff), 17);
         mul_b = PR4;
      end else if (ctrl.av1) begin
         mul_a = h_ff ^ (h_ff >> 15);
         mul_b = PR2;
      end else if (ctrl.av2) begin
         mul_a = h_ff ^ (h_ff >> 13);
         mul_b = PR3;
      end
   end

   assign product = 32'(mul_a * mul_b);

   always_comb begin
      h_in = h_ff;
      p_in = p_ff;
      if (ctrl.fold) begin
         h_in = fold_sum;
      end else if (ctrl.tmul) begin
         p_in = product;
      end else if (ctrl.trot || ctrl.av1 || ctrl.av2) begin
         h_in = product;
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      p_ff <= p_in;
   end

   assign hash = h_ff ^ (h_ff >> 16);

endmodule

>>> hw/rtl/stripe_key_hash_engine.sv
// Stripe key hash engine: 32-bit hash of variable-length keys.
// req channel: one beat per 16-byte stripe, low key bytes in tdata[63:0],
//   high key bytes in tdata[127:64], byte count in tdata[132:128];
//   tlast marks the final stripe of a key. Byte count matters only there.
// rsp channel: one beat per key, the finished hash in tdata[31:0].
// Four lane units absorb a stripe side by side; a merge unit folds the
// lanes, runs the tail round and the avalanche on one shared multiplier.
// A non-final stripe is taken as a product step, then a lane update; no
// further stripe is accepted until the lane update is done. A final
// stripe runs the lane update if absorbed, the fold, the tail round if
// one runs, then AV1 and AV2; the merge sequencer works one key at a time.
// Stalls: the hash sits in an output register; the next key's stripes are
// taken while it waits. A further hash holds in the merge unit until the
// output register frees up, and no beat is taken meanwhile.
// Reset: lanes return to their seed values, no hash pending, ready high.
module stripe_key_hash_engine
   import skh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,   // stripe_low, stripe_high, byte_count
   input  logic         req_tlast,   // last_of_key
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata    // hash
);

   state_type state_ff, state_in;
   logic        last_ff, last_in;
   logic        tail_ff, tail_in;
   logic        seen_ff, seen_in;
   logic        half_ff, half_in;
   logic [63:0] tail_word_ff, tail_word_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic [63:0] stripe_low, stripe_high, high_used;
   logic [4:0]  cnt_raw, cnt_sat;
   logic        accept, mid_count, short_count, absorb, out_take;
   logic [NUM_LANES-1:0][31:0] lane_acc;
   logic [127:0]   lane_words;
   lane_ctrl_type  lane_ctrl;
   merge_ctrl_type merge_ctrl;
   logic [31:0]    merge_hash;

   assign stripe_low  = req_tdata[63:0];
   assign stripe_high = req_tdata[127:64];
   assign cnt_raw     = req_tdata[132:128];
   assign cnt_sat     = (cnt_raw > FULL_STRIPE) ? FULL_STRIPE : cnt_raw;

   assign req_tready  = (state_ff == ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign mid_count   = (cnt_sat > HALF_STRIPE) && (cnt_sat < FULL_STRIPE);
   assign short_count = (cnt_sat != 5'd0) && (cnt_sat <= HALF_STRIPE);
   assign absorb      = !req_tlast || mid_count || (cnt_sat == FULL_STRIPE);
   assign high_used   = (req_tlast && mid_count)
                      ? (stripe_high & low_bytes(4'(cnt_sat - HALF_STRIPE)))
                      : stripe_high;
   assign lane_words  = {high_used, stripe_low};
   assign out_take    = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      tail_in      = tail_ff;
      seen_in      = seen_ff;
      half_in      = half_ff;
      tail_word_in = tail_word_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in      = req_tlast;
               tail_in      = req_tlast && ((cnt_sat == FULL_STRIPE) || short_count
                                            || ((cnt_sat == 5'd0) && seen_ff));
               tail_word_in = (req_tlast && short_count)
                            ? (stripe_low & low_bytes(cnt_sat[3:0])) : 64'd0;
               if (!req_tlast) begin
                  seen_in = 1'b1;
               end
               state_in = absorb ? ST_MIX : ST_FOLD;
            end
         end
         ST_MIX: begin
            state_in = last_ff ? ST_FOLD : ST_IDLE;
         end
         ST_FOLD: begin
            seen_in  = 1'b0;
            half_in  = 1'b0;
            state_in = tail_ff ? ST_TMUL : ST_AV1;
         end
         ST_TMUL: begin
            state_in = ST_TROT;
         end
         ST_TROT: begin
            half_in  = 1'b1;
            state_in = half_ff ? ST_AV1 : ST_TMUL;
         end
         ST_AV1: begin
            state_in = ST_AV2;
         end
         ST_AV2: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_take || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = out_take ? merge_hash : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      tail_ff      <= tail_in;
      half_ff      <= half_in;
      tail_word_ff <= tail_word_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign lane_ctrl.load  = accept && absorb;
   assign lane_ctrl.mix   = (state_ff == ST_MIX);
   assign lane_ctrl.clear = (state_ff == ST_FOLD);

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      skh_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lane_ctrl),
         .word       (lane_words[32*i +: 32]),
         .init_value (LANE_INIT[i]),
         .acc        (lane_acc[i])
      );
   end

   assign merge_ctrl.fold = (state_ff == ST_FOLD);
   assign merge_ctrl.tmul = (state_ff == ST_TMUL);
   assign merge_ctrl.trot = (state_ff == ST_TROT);
   assign merge_ctrl.av1  = (state_ff == ST_AV1);
   assign merge_ctrl.av2  = (state_ff == ST_AV2);

   skh_merge u_merge (
      .clock     (clock),
      .ctrl      (merge_ctrl),
      .lanes     (lane_acc),
      .tail_word (half_ff ? tail_word_ff[63:32] : tail_word_ff[31:0]),
      .hash      (merge_hash)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hw/rtl/skh_checker.sv
`include "assert_macros.svh"

module skh_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tlast,
   input logic         rsp_tvalid,
   input logic         rsp_tready
);

   logic req_beat;

   assign req_beat = req_tvalid && req_tready;

   `SKH_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp_tvalid && req_tready), "reset did not idle the block")
   `SKH_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid, "rsp beat dropped while stalled")
   `SKH_ASSERT(a_mid_rate, clock, reset, (req_beat && !req_tlast) |=> (!req_tready ##1 req_tready), "non-final stripe not two cycles")
   `SKH_ASSERT(a_no_early_rsp, clock, reset, req_beat |=> !$rose(rsp_tvalid), "hash appeared right after a req beat")

endmodule

bind stripe_key_hash_engine skh_checker u_skh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

>>> verif/stripe_key_hash_engine_test.sv
`timescale 1ns / 100ps

module stripe_key_hash_engine_test;

   localparam logic [31:0] PRIME1 = 32'h9E37_79B1;
   localparam logic [31:0] PRIME2 = 32'h85EB_CA77;
   localparam logic [31:0] PRIME3 = 32'hC2B2_AE3D;
   localparam logic [31:0] PRIME4 = 32'h27D4_EB2F;
   localparam int unsigned STRIPE_TARGET = 500;
   localparam int unsigned IDLE_LIMIT = 4000;
   localparam int unsigned MAX_REPORTS = 10;

   typedef struct {
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0]  count;
      logic        last;
      bit          drain_first;  // hold until every hash in flight is back
   } stripe_beat_type;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;   // stripe_low, stripe_high, byte_count
   logic         req_tlast = 1'b0; // last_of_key
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;        // hash

   stripe_beat_type pending_stripes[$];
   logic [31:0]  expected_hashes[$];

   logic [31:0]  lane_acc[4];
   bit           key_has_data;

   int unsigned  mismatch_count = 0;
   int unsigned  gap_left = 0;
   int unsigned  burst_left = 0;
   int unsigned  ready_left = 0;
   int unsigned  stall_left = 0;
   int unsigned  idle_cycles = 0;
   logic [31:0]  want_hash;
   stripe_beat_type next_beat;

   stripe_key_hash_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------- hash predictor ----------------

   function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned r);
      return (v << r) | (v >> (32 - r));
   endfunction

   function automatic logic [63:0] keep_bytes(input int unsigned n);
      if (n >= 8) return '1;
      if (n == 0) return '0;
      return 64'hFFFF_FFFF_FFFF_FFFF >> (8 * (8 - n));
   endfunction

   function automatic logic [31:0] mix_word(input logic [31:0] lane, input logic [31:0] x);
      logic [31:0] acc;
      acc = lane + x * PRIME2;
      return rol32(acc, 13) * PRIME1;
   endfunction

   function automatic void seed_lanes();
      lane_acc[0] = PRIME1 + PRIME2;
      lane_acc[1] = PRIME2;
      lane_acc[2] = 32'h0;
      lane_acc[3] = 32'h0 - PRIME1;
      key_has_data = 1'b0;
   endfunction

   function automatic void absorb_stripe(input logic [63:0] lo, input logic [63:0] hi);
      lane_acc[0] = mix_word(lane_acc[0], lo[31:0]);
      lane_acc[1] = mix_word(lane_acc[1], lo[63:32]);
      lane_acc[2] = mix_word(lane_acc[2], hi[31:0]);
      lane_acc[3] = mix_word(lane_acc[3], hi[63:32]);
   endfunction

   function automatic logic [31:0] fold_lanes();
      return rol32(lane_acc[0], 1) + rol32(lane_acc[1], 7) +
             rol32(lane_acc[2], 12) + rol32(lane_acc[3], 18);
   endfunction

   function automatic logic [31:0] tail_round(input logic [31:0] acc, input logic [63:0] w);
      logic [31:0] a;
      a = acc + w[31:0] * PRIME3;
      a = rol32(a, 17) * PRIME4;
      a = a + w[63:32] * PRIME3;
      a = rol32(a, 17) * PRIME4;
      return a;
   endfunction

   function automatic logic [31:0] avalanche(input logic [31:0] h);
      logic [31:0] v;
      v = h ^ (h >> 15);
      v = v * PRIME2;
      v = v ^ (v >> 13);
      v = v * PRIME3;
      v = v ^ (v >> 16);
      return v;
   endfunction

   function automatic void track_stripe(input logic [63:0] lo, input logic [63:0] hi,
                                        input logic [4:0] count, input logic last);
      logic [31:0] h;
      int unsigned n;
      if (!last) begin
         absorb_stripe(lo, hi);
         key_has_data = 1'b1;
         return;
      end
      n = (count > 5'd16) ? 16 : int'(count);
      if (n > 8 && n < 16) begin
         absorb_stripe(lo, hi & keep_bytes(n - 8));
         h = fold_lanes();
      end else if (n == 16) begin
         absorb_stripe(lo, hi);
         h = tail_round(fold_lanes(), 64'h0);
      end else if (n > 0) begin
         h = tail_round(fold_lanes(), lo & keep_bytes(n));
      end else if (key_has_data) begin
         h = tail_round(fold_lanes(), 64'h0);
      end else begin
         h = fold_lanes();
      end
      expected_hashes.push_back(avalanche(h));
      seed_lanes();
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic void queue_stripe(input logic [63:0] lo, input logic [63:0] hi,
                                        input int unsigned count, input logic last,
                                        input bit drain_first);
      stripe_beat_type b;
      b.lo = lo;
      b.hi = hi;
      b.count = 5'(count);
      b.last = last;
      b.drain_first = drain_first;
      pending_stripes.push_back(b);
   endfunction

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
         gap_left = 0;
         burst_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_stripe(req_tdata[63:0], req_tdata[127:64], req_tdata[132:128], req_tlast);
         end
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_stripes.size() > 0 &&
                         !(pending_stripes[0].drain_first && expected_hashes.size() != 0)) begin
               next_beat = pending_stripes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {3'b000, next_beat.count, next_beat.hi, next_beat.lo};
               req_tlast <= next_beat.last;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor and receiver stalls ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_left = 0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hashes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("unexpected hash beat: got %08h", rsp_tdata);
               end
            end else begin
               want_hash = expected_hashes.pop_front();
               if (rsp_tdata !== want_hash) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("hash mismatch: expected %08h got %08h", want_hash, rsp_tdata);
                  end
               end
            end
         end
         if (ready_left > 0) begin
            ready_left--;
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            ready_left = $urandom_range(1, 30);
            stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------- watchdog ----------------

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ---------------- sequence ----------------

   initial begin
      int unsigned total;
      int unsigned body;
      int unsigned cnt;
      int unsigned keys;
      seed_lanes();

      // directed: single-stripe keys over each byte-count class
      queue_stripe(rand_word(), rand_word(), 0, 1'b1, 1'b0);            // empty key
      queue_stripe('1, '1, 1, 1'b1, 1'b0);
      queue_stripe('1, '1, 8, 1'b1, 1'b0);
      queue_stripe('1, '1, 9, 1'b1, 1'b0);
      queue_stripe({$urandom, $urandom}, '1, 15, 1'b1, 1'b0);
      queue_stripe('1, '1, 16, 1'b1, 1'b0);
      queue_stripe({$urandom, $urandom}, {$urandom, $urandom}, 17, 1'b1, 1'b0);
      queue_stripe('1, '1, 31, 1'b1, 1'b0);                             // saturates
      queue_stripe('0, '0, 16, 1'b1, 1'b0);
      // multi-stripe keys
      queue_stripe('1, '1, 0, 1'b0, 1'b1);
      queue_stripe({$urandom, $urandom}, {$urandom, $urandom}, 0, 1'b1, 1'b0);  // zero after data
      queue_stripe({$urandom, $urandom}, {$urandom, $urandom}, 5, 1'b0, 1'b0);  // count ignored
      queue_stripe('0, '0, 31, 1'b0, 1'b0);
      queue_stripe({$urandom, $urandom}, '1, 12, 1'b1, 1'b0);
      queue_stripe({$urandom, $urandom}, {$urandom, $urandom}, 16, 1'b0, 1'b0);
      queue_stripe({$urandom, $urandom}, {$urandom, $urandom}, 16, 1'b1, 1'b0);
      queue_stripe('0, '0, 3, 1'b0, 1'b0);
      queue_stripe('1, {$urandom, $urandom}, 3, 1'b1, 1'b0);
      queue_stripe({$urandom, $urandom}, '1, 7, 1'b0, 1'b0);
      queue_stripe('1, '1, 24, 1'b1, 1'b0);
      total = pending_stripes.size();

      keys = 0;
      while (total < STRIPE_TARGET) begin
         body = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
         for (int i = 0; i < body; i++) begin
            queue_stripe(rand_word(), rand_word(), $urandom_range(0, 31), 1'b0,
                         (i == 0) && (keys % 40 == 39));
         end
         cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 16);
         queue_stripe(rand_word(), rand_word(), cnt, 1'b1, (body == 0) && (keys % 40 == 39));
         total += body + 1;
         keys++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_stripes.size() != 0 || req_tvalid || expected_hashes.size() != 0) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && expected_hashes.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
